[hw/rtl/fifo_or_priority_server_core_defines.svh]
// assertion macros used by the core rtl file
`ifndef FIFO_OR_PRIORITY_SERVER_CORE_DEFINES_SVH
`define FIFO_OR_PRIORITY_SERVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define FOPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define FOPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FOPS_ASSERT(lbl, prop, msg)
`define FOPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/fops_pkg.sv]
`default_nettype none

package fops_pkg;

  // sizes
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned VALUE_W  = 20;
  localparam int unsigned MONEY_W  = 20;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 2;

  // packed stream widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // command codes
  localparam logic [OP_W-1:0] OP_ARRIVE     = 2'd0;
  localparam logic [OP_W-1:0] OP_SERVE_OLD  = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVE_BEST = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OLD_RD,
    S_OLD_CHK,
    S_BEST,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/fops_ram.sv]
`default_nettype none

module fops_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/fifo_or_priority_server_core.sv]
// Request server with oldest-first and highest-value-first service.
// Input stream: tuser carries the command (arrival, serve oldest, serve best),
// tdata carries the 20-bit value of an arriving request. Every command yields
// exactly one output word: tuser is the status, tdata the request id (ids
// count from 1, 0 when nothing is returned).
// One command is handled at a time; s_axis_tready is high only while the
// sequencer is idle. An arrival or an unused command goes from idle to the
// response state and then to the output register. Serve oldest reads the mark
// at the oldest pointer, skipping entries already served, and answers empty
// when nothing is pending. Serve best sweeps every stored entry through the
// value and mark memories, one read per cycle. Of the store state, reset
// clears only the arrival count and the oldest pointer; memory entries at or
// above the arrival count are never used, so no clearing pass runs. A
// finished word sits in the output register until the receiver takes it;
// the next command is accepted meanwhile, but its own result waits until the
// register frees up.
`default_nettype none
`include "fifo_or_priority_server_core_defines.svh"

module fifo_or_priority_server_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input words
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [fops_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [19:0] money
  input  wire logic [fops_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] op
  // result words
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [fops_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [10:0] served_id
  output logic      [fops_pkg::STAT_W-1:0]        m_axis_tuser   // [1:0] status
);

  import fops_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [VALUE_W-1:0] best_val_q, best_val_d;

  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;

  logic               out_vld_q, out_vld_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;

  // memory ports
  logic               val_we;
  logic [VALUE_W-1:0] val_rdata;
  logic               mark_we;
  logic               mark_wdata;
  logic [IDX_W-1:0]   mark_waddr;
  logic [IDX_W-1:0]   rd_addr;
  logic               mark_rdata;

  logic               in_acc;
  logic               out_free;
  logic               scan_issue;
  logic               scan_done;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] money;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign op         = s_axis_tuser;
  assign money      = VALUE_W'(s_axis_tdata[MONEY_W-1:0]);
  assign scan_issue = scan_q < count_q;
  assign scan_done  = !scan_issue && !rd_vld_q;

  // value store and served marks
  fops_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (money),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  fops_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mark_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_SERVE_OLD) begin
            state_d = S_OLD_RD;
          end else if (op == OP_SERVE_BEST) begin
            state_d = S_BEST;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_OLD_RD: begin
        state_d = (ptr_q < count_q) ? S_OLD_CHK : S_RESP;
      end
      S_OLD_CHK: begin
        state_d = mark_rdata ? S_OLD_RD : S_RESP;
      end
      S_BEST: begin
        if (scan_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    res_stat_d = res_stat_q;
    res_id_d   = res_id_q;
    val_we     = 1'b0;
    mark_we    = 1'b0;
    mark_wdata = 1'b0;
    mark_waddr = count_q[IDX_W-1:0];
    rd_addr    = scan_q[IDX_W-1:0];
    s_axis_tready = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        scan_d   = '0;
        found_d  = 1'b0;
        if (in_acc) begin
          res_stat_d = ST_EMPTY;
          res_id_d   = '0;
          if (op == OP_ARRIVE) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_stat_d = ST_FULL;
            end else begin
              // new entry: store value, clear its mark
              val_we     = 1'b1;
              mark_we    = 1'b1;
              mark_wdata = 1'b0;
              count_d    = count_q + 1'b1;
              res_stat_d = ST_ACCEPTED;
              res_id_d   = ID_W'(count_d);
            end
          end
        end
      end
      S_OLD_RD: begin
        rd_addr = ptr_q[IDX_W-1:0];
        if (ptr_q >= count_q) begin
          res_stat_d = ST_EMPTY;
          res_id_d   = '0;
        end
      end
      S_OLD_CHK: begin
        // skip served entries, else serve this one
        ptr_d = ptr_q + 1'b1;
        if (!mark_rdata) begin
          mark_we    = 1'b1;
          mark_wdata = 1'b1;
          mark_waddr = ptr_q[IDX_W-1:0];
          res_stat_d = ST_SERVED;
          res_id_d   = ID_W'(ptr_d);
        end
      end
      S_BEST: begin
        // issue one read per cycle, compare the word read last cycle
        rd_vld_d = scan_issue;
        rd_idx_d = scan_q[IDX_W-1:0];
        if (scan_issue) begin
          scan_d = scan_q + 1'b1;
        end
        if (rd_vld_q && !mark_rdata && (!found_q || val_rdata > best_val_q)) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_val_d = val_rdata;
        end
        if (scan_done) begin
          if (found_q) begin
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
            mark_waddr = best_idx_q;
            res_stat_d = ST_SERVED;
            res_id_d   = ID_W'({1'b0, best_idx_q} + CNT_W'(1));
          end else begin
            res_stat_d = ST_EMPTY;
            res_id_d   = '0;
          end
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_stat_d = out_stat_q;
    out_id_d   = out_id_q;
    if (state_q == S_RESP && out_free) begin
      out_vld_d  = 1'b1;
      out_stat_d = res_stat_q;
      out_id_d   = res_id_q;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    res_stat_q <= res_stat_d;
    res_id_q   <= res_id_d;
    out_stat_q <= out_stat_d;
    out_id_q   <= out_id_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_id_q);

  // checks
  `FOPS_ASSERT(a_ptr_in_range, ptr_q <= count_q, "oldest pointer beyond arrival count")
  `FOPS_ASSERT(a_served_id_ok, !(out_vld_q && out_stat_q == ST_SERVED) || (out_id_q != '0 && ID_W'(count_q) >= out_id_q), "served id outside stored range")
  `FOPS_ASSERT_NEXT(a_busy_after_accept, in_acc, state_q != S_IDLE, "sequencer idle after accepting a word")
  `FOPS_ASSERT(a_scan_in_range, state_q != S_BEST || scan_q <= count_q, "best scan index beyond arrival count")

endmodule

`default_nettype wire

[bench/request_server_checker.sv]
`timescale 1ns / 100ps

module request_server_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel as seen at the block input
  input  logic                              cmd_valid_i,
  input  logic                              cmd_ready_i,
  input  logic [fops_pkg::IN_DATA_W-1:0]    cmd_data_i,    // [19:0] money
  input  logic [fops_pkg::OP_W-1:0]         cmd_op_i,      // [1:0] op
  // reply channel as seen at the block output
  input  logic                              reply_valid_i,
  input  logic                              reply_ready_i,
  input  logic [fops_pkg::OUT_DATA_W-1:0]   reply_data_i,  // [10:0] served_id
  input  logic [fops_pkg::STAT_W-1:0]       reply_status_i, // [1:0] status
  output int                                pending_o,
  output int                                fail_count_o
);
  import fops_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
  } reply_t;

  // shadow copy of the request store
  logic [VALUE_W-1:0] value_mem [CAPACITY];
  bit                 served_mem [CAPACITY];
  int unsigned        arrivals;
  int unsigned        oldest;

  reply_t expected_replies [$];

  // apply one command to the shadow store and return the reply it earns
  function automatic reply_t serve_command(logic [OP_W-1:0] op, logic [MONEY_W-1:0] money);
    reply_t      r;
    int unsigned best;
    bit          found;
    r.status = ST_EMPTY;
    r.id     = '0;
    best     = 0;
    found    = 1'b0;
    case (op)
      OP_ARRIVE: begin
        if (arrivals >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          value_mem[arrivals]  = money[VALUE_W-1:0];
          served_mem[arrivals] = 1'b0;
          arrivals++;
          r.status = ST_ACCEPTED;
          r.id     = ID_W'(arrivals);
        end
      end
      OP_SERVE_OLD: begin
        // skip entries already taken by a best-first serve
        while (oldest < arrivals && served_mem[oldest]) oldest++;
        if (oldest < arrivals) begin
          served_mem[oldest] = 1'b1;
          oldest++;
          r.status = ST_SERVED;
          r.id     = ID_W'(oldest);
        end
      end
      OP_SERVE_BEST: begin
        // strict greater keeps the lowest id on equal values
        for (int unsigned i = 0; i < arrivals; i++) begin
          if (!served_mem[i] && (!found || value_mem[i] > value_mem[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          served_mem[best] = 1'b1;
          r.status = ST_SERVED;
          r.id     = ID_W'(best + 1);
        end
      end
      default: begin
        r.status = ST_EMPTY;
      end
    endcase
    return r;
  endfunction

  // compare reply words first, then queue the prediction for a new command
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      arrivals = 0;
      oldest   = 0;
      foreach (served_mem[i]) served_mem[i] = 1'b0;
      expected_replies.delete();
      pending_o = 0;
    end else begin
      if (reply_valid_i && reply_ready_i) begin
        got.status = reply_status_i;
        got.id     = reply_data_i[ID_W-1:0];
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply word, expected none, got status %0d id %0d",
                   $time, got.status, got.id);
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.id !== want.id) begin
            $display("%0t: reply mismatch, expected status %0d id %0d, got status %0d id %0d",
                     $time, want.status, want.id, got.status, got.id);
            fail_count_o++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        expected_replies.insert(expected_replies.size(),
                                serve_command(cmd_op_i, cmd_data_i[MONEY_W-1:0]));
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import fops_pkg::*;

  // command code the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 112;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  int pending;
  int failures;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;

  always #1 clk_i = ~clk_i;

  fifo_or_priority_server_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  request_server_checker u_reply_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_i    (s_axis_tready),
    .cmd_data_i     (s_axis_tdata),
    .cmd_op_i       (s_axis_tuser),
    .reply_valid_i  (m_axis_tvalid),
    .reply_ready_i  (m_axis_tready),
    .reply_data_i   (m_axis_tdata),
    .reply_status_i (m_axis_tuser),
    .pending_o      (pending),
    .fail_count_o   (failures)
  );

  // overall watchdog
  initial begin
    #10000000;
    $display("*** FAILED ***");
    $finish;
  end

  // reply side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // offer one command word and wait for it to be taken
  task automatic send_word(input logic [OP_W-1:0] op, input logic [MONEY_W-1:0] money);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'(money);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // values: half full range, some narrow for ties, some at the extremes
  function automatic logic [MONEY_W-1:0] pick_value();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) return MONEY_W'($urandom());
    if (kind < 8) return MONEY_W'($urandom_range(0, 7));
    if (kind == 8) return '1;
    return '0;
  endfunction

  // stop offering until every reply is back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                           input bit with_hold);
    int unsigned pick;
    logic [OP_W-1:0] op;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if (with_hold && i == items / 4) hold_requests++;
      pick = $urandom_range(0, 99);
      if (pick < 44)      op = OP_ARRIVE;
      else if (pick < 66) op = OP_SERVE_OLD;
      else if (pick < 95) op = OP_SERVE_BEST;
      else                op = OP_SPARE;
      send_word(op, pick_value());
    end
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty serves, spare code, extreme and tied values, skips
    send_word(OP_SERVE_OLD,  '1);
    send_word(OP_SERVE_BEST, '1);
    send_word(OP_SPARE,      '1);
    send_word(OP_ARRIVE,     20'h00000);
    send_word(OP_ARRIVE,     20'hFFFFF);
    send_word(OP_ARRIVE,     20'h55555);
    send_word(OP_ARRIVE,     20'hAAAAA);
    send_word(OP_ARRIVE,     20'hFFFFF);
    send_word(OP_ARRIVE,     20'h00000);
    send_word(OP_SERVE_BEST, 20'h00000);
    send_word(OP_SERVE_BEST, 20'h00000);
    send_word(OP_SERVE_OLD,  20'hFFFFF);
    send_word(OP_SERVE_BEST, 20'h00000);
    send_word(OP_SERVE_OLD,  20'h00000);
    send_word(OP_SERVE_OLD,  20'h00000);
    send_word(OP_SERVE_OLD,  20'h00000);
    send_word(OP_SERVE_BEST, 20'h00000);
    send_word(OP_SPARE,      20'h00000);
    drain();

    // random phases with different idle patterns
    run_phase(PHASE_ITEMS, 0,  0,  1'b0);
    run_phase(PHASE_ITEMS, 72, 0,  1'b0);
    run_phase(PHASE_ITEMS, 0,  72, 1'b0);
    run_phase(PHASE_ITEMS, 31, 31, 1'b0);
    run_phase(PHASE_ITEMS, 0,  0,  1'b1);

    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fops_pkg.sv
hw/rtl/fops_ram.sv
hw/rtl/fifo_or_priority_server_core.sv
bench/request_server_checker.sv
bench/tb_top.sv
